[rtl/mtflru_pkg.sv]
// Package for the move-to-front LRU tail core: word widths, reset length
// and the control struct broadcast from the core to every list cell.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtflru_pkg;

  localparam int WORD_W = 8;
  localparam int LEN_W = 5;
  localparam int TAIL_W = 5;
  localparam int DEPTH_DEFAULT = 16;
  localparam logic [LEN_W-1:0] LIST_LENGTH_RESET = 5'd16;

  typedef struct packed {
    logic load;
    logic sample;
    logic move;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/mtflru_cell.sv]
// One list cell: holds one entry, compares it to a request and on a move
// takes its front neighbor's entry if it or one behind hit. Depends on mtflru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtflru_cell
  import mtflru_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int INDEX = 0,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire              clk,
  input  wire cell_ctrl_t  ctrl,
  input  wire  [CNT_W-1:0] load_count,
  input  wire  [WORD_W-1:0] cmp_value,
  input  wire  [WORD_W-1:0] prev_value,
  input  wire              seen_in,
  output logic             seen_out,
  output logic [WORD_W-1:0] value,
  output logic [WORD_W-1:0] value_next
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(INDEX);
  localparam logic [WORD_W-1:0] LOAD_C = WORD_W'(INDEX + 1);

  logic hit;
  logic take;

  assign seen_out = seen_in | hit;
  assign take = ctrl.move & (hit | seen_in);

  always_comb begin
    priority if (ctrl.load) begin
      value_next = (IDX_C < load_count) ? LOAD_C : '0;
    end else if (take) begin
      value_next = prev_value;
    end else begin
      value_next = value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    if (ctrl.sample) begin
      hit <= (value == cmp_value) && (cmp_value != '0);
    end
  end

endmodule

`default_nettype wire

[rtl/move_to_front_lru_tail_core.sv]
// Move-to-front LRU tracker top level: a chain of list cells, the request
// and result registers and the length register. Depends on mtflru_pkg and
// mtflru_cell.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      in_valid / in_stall        request_value
//   out       output     out_valid / out_stall      tail_value, rejected
//   config    input      list_length_we             list_length
//
// For each word, every cell compares its entry in the accept cycle; then
// the match ripples toward the front through the cells while the list
// shifts and the result register loads. The next word is taken only after
// that move. Reset loads the list as 1..min(16, DEPTH). While the result
// register is full and stalled, the move waits and in_stall stays high.
`timescale 1ns / 1ps
`default_nettype none

module move_to_front_lru_tail_core
  import mtflru_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               list_length_we,
  input  wire  [LEN_W-1:0]  list_length,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire  [WORD_W-1:0] request_value,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [TAIL_W-1:0] tail_value,
  output logic              rejected
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

  logic              busy;
  logic [WORD_W-1:0] request;
  logic [CNT_W-1:0]  count;
  logic [CMP_W-1:0]  len_src;
  logic [CMP_W-1:0]  len_sat;
  logic [CNT_W-1:0]  load_count;
  logic [IDX_W-1:0]  tail_idx;
  logic              accept;
  logic              finish;
  cell_ctrl_t        ctrl;

  logic [WORD_W-1:0] values [DEPTH];
  logic [WORD_W-1:0] values_next [DEPTH];
  logic [DEPTH:0]    seen;

  assign len_src = CMP_W'(rst ? LIST_LENGTH_RESET : list_length);

  always_comb begin
    priority if (len_src == '0) begin
      len_sat = CMP_W'(1);
    end else if (len_src > DEPTH_C) begin
      len_sat = DEPTH_C;
    end else begin
      len_sat = len_src;
    end
  end

  assign load_count = CNT_W'(len_sat);
  assign tail_idx = IDX_W'(count - CNT_W'(1));

  assign in_stall = busy;
  assign accept = in_valid & ~busy;
  assign finish = busy & (~out_valid | ~out_stall);

  assign ctrl.load = rst | list_length_we;
  assign ctrl.sample = accept;
  assign ctrl.move = finish;

  assign seen[DEPTH] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] prev;
    if (i == 0) begin : g_front
      assign prev = request;
    end else begin : g_inner
      assign prev = values[i-1];
    end
    mtflru_cell #(
      .DEPTH(DEPTH),
      .INDEX(i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .load_count(load_count),
      .cmp_value (request_value),
      .prev_value(prev),
      .seen_in   (seen[i+1]),
      .seen_out  (seen[i]),
      .value     (values[i]),
      .value_next(values_next[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
      count <= load_count;
    end else begin
      if (list_length_we) begin
        count <= load_count;
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      request <= request_value;
    end
    if (finish) begin
      tail_value <= TAIL_W'(values_next[tail_idx]);
      rejected <= ~seen[0];
    end
  end

endmodule

`default_nettype wire
